### rtl/signed_int_to_custom_radix_digits_assert.svh
// Assertion macros for the RTL of the radix text converter.
// Define ASSERT_OFF to compile every assertion away.
`ifndef SIGNED_INT_TO_CUSTOM_RADIX_DIGITS_ASSERT_SVH
`define SIGNED_INT_TO_CUSTOM_RADIX_DIGITS_ASSERT_SVH

`ifndef ASSERT_OFF
// The implication or expression must hold at every clock edge out of reset.
`define SCRD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// The expression must never be true out of reset.
`define SCRD_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define SCRD_ASSERT(lbl, prop, msg)
`define SCRD_NEVER(lbl, expr, msg)
`endif

`endif

### rtl/scrd_pkg.sv
package scrd_pkg;

  localparam int MAG_W     = 32;
  localparam int DIV_BITS  = 8;
  localparam int DIV_STEPS = MAG_W / DIV_BITS;
  localparam int DIGIT_W   = 5;
  localparam int RADIX_W   = 6;
  localparam int CHAR_W    = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 64;

  typedef logic [CHAR_W-1:0] char_t;

  localparam char_t CH_MINUS     = 8'h2D;
  localparam char_t CH_PLUS      = 8'h2B;
  localparam char_t CH_LOW_LIMIT = 8'd31;
  localparam char_t CH_DEL       = 8'd127;
  localparam char_t CH_NUL       = 8'd0;

  localparam logic [RADIX_W-1:0] MIN_RADIX = 6'd2;
  localparam logic [RADIX_W-1:0] BASE_LEN_RESET = 6'd10;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_LEN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA0   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA3   = 3'd4;

  // Reset alphabet, character k in byte k: the ten decimal digits.
  localparam logic [4*CFG_W-1:0] ALPHA_RESET = {64'd0, 64'd0, 64'd14648,
                                                64'd3978425819141910832};

  typedef struct packed {
    logic done;
    logic ok;
  } vld_st_t;

  typedef struct packed {
    logic               done;
    logic [MAG_W-1:0]   quot;
    logic [DIGIT_W-1:0] rem;
  } div_res_t;

endpackage

### rtl/scrd_valid.sv
module scrd_valid #(
  parameter int MAX_ALPHABET = 32
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    start,
  input  logic [scrd_pkg::RADIX_W-1:0]            base_len,
  input  logic [MAX_ALPHABET-1:0][scrd_pkg::CHAR_W-1:0] alpha,
  input  scrd_pkg::char_t                         char_sel,
  output logic [$clog2(MAX_ALPHABET)-1:0]         idx,
  output scrd_pkg::vld_st_t                       status
);
  import scrd_pkg::*;

  localparam int AW = $clog2(MAX_ALPHABET);

  typedef enum logic {V_IDLE, V_SCAN} vstate_t;

  vstate_t       state_r;
  logic [AW-1:0] idx_r;
  logic          done_r;
  logic          ok_r;
  logic          bad_char;
  logic          dup;
  logic          len_bad;
  logic          at_end;

  // The selected character is checked for forbidden codes and against every
  // later character of the alphabet at once; one character per cycle.
  always_comb begin
    bad_char = (char_sel == CH_MINUS) || (char_sel == CH_PLUS) ||
               (char_sel <= CH_LOW_LIMIT) || (char_sel >= CH_DEL);
    dup = 1'b0;
    for (int j = 0; j < MAX_ALPHABET; j++) begin
      if ((RADIX_W'(j) > RADIX_W'(idx_r)) && (RADIX_W'(j) < base_len) &&
          (alpha[j] == char_sel)) begin
        dup = 1'b1;
      end
    end
  end

  assign len_bad = (base_len < MIN_RADIX) || (base_len > RADIX_W'(MAX_ALPHABET));
  assign at_end  = (RADIX_W'(idx_r) == base_len - 1'b1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= V_IDLE;
      idx_r   <= '0;
      done_r  <= 1'b0;
      ok_r    <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        V_IDLE: begin
          if (start) begin
            if (len_bad) begin
              done_r <= 1'b1;
              ok_r   <= 1'b0;
            end else begin
              idx_r   <= '0;
              state_r <= V_SCAN;
            end
          end
        end
        V_SCAN: begin
          if (bad_char || dup) begin
            done_r  <= 1'b1;
            ok_r    <= 1'b0;
            state_r <= V_IDLE;
          end else if (at_end) begin
            done_r  <= 1'b1;
            ok_r    <= 1'b1;
            state_r <= V_IDLE;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        default: state_r <= V_IDLE;
      endcase
    end
  end

  assign idx         = idx_r;
  assign status.done = done_r;
  assign status.ok   = ok_r;

endmodule

### rtl/scrd_div.sv
module scrd_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [scrd_pkg::MAG_W-1:0]    dividend,
  input  logic [scrd_pkg::RADIX_W-1:0]  divisor,
  output scrd_pkg::div_res_t            res
);
  import scrd_pkg::*;

  localparam int SW = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  logic [MAG_W-1:0]   q_r;
  logic [DIGIT_W-1:0] rem_r;
  logic [SW-1:0]      cnt_r;
  logic               busy_r;
  logic               done_r;
  logic [MAG_W-1:0]   q_step;
  logic [DIGIT_W-1:0] rem_step;
  logic [DIGIT_W:0]   trial;

  // Restoring division, several quotient bits per cycle. The remainder stays
  // below the divisor, so each trial fits in one bit more than a digit.
  always_comb begin
    q_step   = q_r;
    rem_step = rem_r;
    trial    = '0;
    for (int b = 0; b < DIV_BITS; b++) begin
      trial  = {rem_step, q_step[MAG_W-1]};
      q_step = {q_step[MAG_W-2:0], 1'b0};
      if (trial >= divisor) begin
        rem_step  = DIGIT_W'(trial - divisor);
        q_step[0] = 1'b1;
      end else begin
        rem_step = trial[DIGIT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == SW'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      q_r   <= q_step;
      rem_r <= rem_step;
    end
  end

  assign res.done = done_r;
  assign res.quot = q_r;
  assign res.rem  = rem_r;

endmodule

### rtl/signed_int_to_custom_radix_digits.sv
// Each accepted word runs through the alphabet check, one character a cycle, and then the
// repeated division by the radix, which stores one digit per division; a minus sign, if any,
// is loaded first, then each digit is read from the store and loaded, most significant first.
// Throughput: one number at a time; a new word is accepted once the last character is loaded.
// An invalid alphabet yields a single error word.
// Reset is synchronous and active low; it restores radix ten with the decimal alphabet.
module signed_int_to_custom_radix_digits #(
  parameter int MAX_DIGITS   = 32,
  parameter int MAX_ALPHABET = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [scrd_pkg::MAG_W-1:0] in_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output scrd_pkg::char_t                   out_char,
  output logic                              out_last,
  output logic                              out_base_invalid,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [scrd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [scrd_pkg::CFG_W-1:0]        cfg_data
);
  import scrd_pkg::*;

  localparam int AW = $clog2(MAX_ALPHABET);
  localparam int IW = $clog2(MAX_DIGITS);
  localparam int CW = $clog2(MAX_DIGITS + 1);

  // The sequencer walks each number through the alphabet check, the repeated
  // division and then the emission of the stored digits from the most
  // significant end.
  typedef enum logic [2:0] {
    S_IDLE, S_VALIDATE, S_DIVIDE, S_SIGN, S_READ, S_EMIT, S_ERR
  } state_t;

  // Configuration registers. Only the characters that the alphabet can
  // hold are kept; the rest of each alphabet word is dropped on write.
  logic [RADIX_W-1:0]                  base_len_r;
  logic [MAX_ALPHABET-1:0][CHAR_W-1:0] alpha_r;

  state_t        state_r, state_nxt;
  logic          neg_r, neg_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [IW-1:0] ptr_r, ptr_nxt;
  logic          out_valid_r, out_valid_nxt;

  // Payload registers.
  logic [MAG_W-1:0]   mag_r;
  logic [DIGIT_W-1:0] rd_digit_r;
  char_t              out_char_r;
  logic               out_last_r;
  logic               out_bad_r;

  // Digit store, written by the division loop and read back in reverse.
  logic [DIGIT_W-1:0] digit_mem [MAX_DIGITS];

  logic          in_acc;
  logic          cfg_we;
  logic          slot_free;
  logic          load;
  char_t         load_char;
  logic          load_last;
  logic          load_bad;
  logic          mem_we;
  logic          div_start;
  logic [MAG_W-1:0] div_dividend;
  logic [MAG_W-1:0] mag_in;
  logic [AW-1:0] vld_idx;
  logic [AW-1:0] char_idx;
  char_t         sel_char;
  vld_st_t       vld_st;
  div_res_t      div_res;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  // Two's complement magnitude at full width: the most negative value maps
  // onto itself, which read as unsigned is the correct magnitude.
  assign mag_in = in_value[MAG_W-1] ? (~in_value + 1'b1) : in_value;

  // One read port onto the alphabet, shared between the check and emission,
  // which never run together.
  assign char_idx = (state_r == S_VALIDATE) ? vld_idx : rd_digit_r[AW-1:0];
  assign sel_char = alpha_r[char_idx];

  scrd_valid #(
    .MAX_ALPHABET (MAX_ALPHABET)
  ) u_valid (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_acc),
    .base_len (base_len_r),
    .alpha    (alpha_r),
    .char_sel (sel_char),
    .idx      (vld_idx),
    .status   (vld_st)
  );

  // A digit is stored whenever a division completes. The next division
  // starts straight away on the quotient unless that quotient is zero; the
  // first one starts on the magnitude once the alphabet has passed.
  assign mem_we       = (state_r == S_DIVIDE) && div_res.done;
  assign div_start    = ((state_r == S_VALIDATE) && vld_st.done && vld_st.ok) ||
                        (mem_we && (div_res.quot != '0));
  assign div_dividend = (state_r == S_DIVIDE) ? div_res.quot : mag_r;

  scrd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (base_len_r),
    .res      (div_res)
  );

  // The output register frees itself when its word is taken, so a new word
  // may be loaded in the same cycle as the old one leaves.
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    neg_nxt       = neg_r;
    cnt_nxt       = cnt_r;
    ptr_nxt       = ptr_r;
    out_valid_nxt = out_valid_r && !out_ready;
    load          = 1'b0;
    load_char     = CH_NUL;
    load_last     = 1'b0;
    load_bad      = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          neg_nxt   = in_value[MAG_W-1];
          state_nxt = S_VALIDATE;
        end
      end
      S_VALIDATE: begin
        if (vld_st.done) begin
          cnt_nxt   = '0;
          state_nxt = vld_st.ok ? S_DIVIDE : S_ERR;
        end
      end
      S_DIVIDE: begin
        if (div_res.done) begin
          cnt_nxt = cnt_r + 1'b1;
          if (div_res.quot == '0) begin
            // The digit written in this cycle is the most significant one.
            ptr_nxt   = cnt_r[IW-1:0];
            state_nxt = neg_r ? S_SIGN : S_READ;
          end
        end
      end
      S_SIGN: begin
        if (slot_free) begin
          load      = 1'b1;
          load_char = CH_MINUS;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) begin
          load      = 1'b1;
          load_char = sel_char;
          load_last = (ptr_r == '0);
          if (ptr_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            ptr_nxt   = ptr_r - 1'b1;
            state_nxt = S_READ;
          end
        end
      end
      S_ERR: begin
        if (slot_free) begin
          load      = 1'b1;
          load_char = CH_NUL;
          load_last = 1'b1;
          load_bad  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      neg_r       <= 1'b0;
      cnt_r       <= '0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      neg_r       <= neg_nxt;
      cnt_r       <= cnt_nxt;
      ptr_r       <= ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mag_r <= mag_in;
    end
    if (load) begin
      out_char_r <= load_char;
      out_last_r <= load_last;
      out_bad_r  <= load_bad;
    end
  end

  // Digit store with a registered read; the read address is held through
  // the emit state, so the data stays put while the output stalls.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      digit_mem[cnt_r[IW-1:0]] <= div_res.rem;
    end
    rd_digit_r <= digit_mem[ptr_r];
  end

  // Configuration writes. Indices beyond the register list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_len_r <= BASE_LEN_RESET;
      for (int k = 0; k < MAX_ALPHABET; k++) begin
        alpha_r[k] <= ALPHA_RESET[k * CHAR_W +: CHAR_W];
      end
    end else if (cfg_we) begin
      if (cfg_index == REG_BASE_LEN) begin
        base_len_r <= cfg_data[RADIX_W-1:0];
      end
      for (int k = 0; k < MAX_ALPHABET; k++) begin
        if (cfg_index == CFG_IDX_W'(REG_ALPHA0 + CFG_IDX_W'(k >> 3))) begin
          alpha_r[k] <= cfg_data[(k & 7) * CHAR_W +: CHAR_W];
        end
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_char         = out_char_r;
  assign out_last         = out_last_r;
  assign out_base_invalid = out_bad_r;

`include "signed_int_to_custom_radix_digits_assert.svh"

  // An error word carries no character and always closes the number.
  `SCRD_ASSERT(a_err_word, (out_valid && out_base_invalid) |-> (out_last && out_char == CH_NUL), "error word malformed")
  // The divider only finishes while the sequencer waits on it.
  `SCRD_ASSERT(a_div_owner, div_res.done |-> (state_r == S_DIVIDE), "division result outside the divide state")
  // The alphabet check only reports while the sequencer waits on it.
  `SCRD_ASSERT(a_vld_owner, vld_st.done |-> (state_r == S_VALIDATE), "alphabet check result out of turn")
  // Every stored digit lies below the radix.
  `SCRD_ASSERT(a_digit_range, mem_we |-> (RADIX_W'(div_res.rem) < base_len_r), "digit not below the radix")
  // Emission never reads beyond the digits that were stored.
  `SCRD_NEVER(a_ptr_range, (state_r == S_EMIT) && (CW'(ptr_r) >= cnt_r), "digit pointer beyond the stored count")

endmodule
